// ----- hdl/lfu_page_replacement_macros.svh -----
// assertion macros for the lfu page replacement block
// expects clk and rst in the including module's scope
`ifndef LFU_PAGE_REPLACEMENT_MACROS_SVH
`define LFU_PAGE_REPLACEMENT_MACROS_SVH

// same-cycle implication
`define LFU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfu check failed: same cycle");

// next-cycle implication
`define LFU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfu check failed: next cycle");

`endif

// ----- hdl/lfu_pkg.sv -----
// shared types and constants for the lfu page replacement block
// no dependencies
`default_nettype none

package lfu_pkg;

  localparam int NUM_PAGES   = 64;
  localparam int NUM_FRAMES  = 16;
  localparam int COUNT_BITS  = 16;
  localparam int PAGE_W      = 6;
  localparam int FRAME_W     = 4;
  localparam int PAGES_CFG_W = 7;
  localparam int FRAMES_CFG_W = 5;
  localparam int CFG_DATA_W  = 7;
  localparam int SCAN_W      = $clog2(NUM_FRAMES + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic CFG_PAGES  = 1'b0;
  localparam logic CFG_FRAMES = 1'b1;

  typedef enum logic [2:0] {
    OP_ACCESS  = 3'd0,
    OP_SELECT  = 3'd1,
    OP_REPLACE = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_INSTALL = 3'd4
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic                    do_access;
    logic                    do_replace;
    logic                    do_clear;
    logic                    do_install;
    logic [PAGE_W-1:0]       pg;
    logic [PAGE_W-1:0]       np;
    logic [FRAME_W-1:0]      fr;
    logic [PAGES_CFG_W-1:0]  pages_lim;
    logic [FRAMES_CFG_W-1:0] frames_lim;
  } cell_cmd_t;

  typedef struct packed {
    logic hit_pg;
    logic used;
  } cell_stat_t;

  typedef struct packed {
    logic                  found;
    logic [COUNT_BITS-1:0] best;
    logic [PAGE_W-1:0]     page;
  } cand_t;

endpackage

`default_nettype wire

// ----- hdl/lfu_frame_cell.sv -----
// one frame cell: page tag, used flag, count, and one stage of the victim scan
// depends on lfu_pkg
`default_nettype none

module lfu_frame_cell (
  input  wire                          clk,
  input  wire                          rst,
  input  wire  [lfu_pkg::FRAME_W-1:0]  idx,
  input  lfu_pkg::cell_cmd_t           cmd,
  input  lfu_pkg::cand_t               cin,
  output lfu_pkg::cand_t               cout,
  output lfu_pkg::cell_stat_t          stat
);
  import lfu_pkg::*;

  logic                  used;
  logic [PAGE_W-1:0]     page;
  logic [COUNT_BITS-1:0] count;
  logic                  hit_pg;
  logic                  hit_np;
  logic                  sel_install;
  logic                  in_range;
  logic                  take;
  cand_t                 cout_next;

  assign hit_pg      = used && (page == cmd.pg);
  assign hit_np      = used && (page == cmd.np);
  assign sel_install = cmd.do_install && (cmd.fr == idx);
  assign in_range    = (FRAMES_CFG_W'(idx) < cmd.frames_lim);

  assign stat.hit_pg = hit_pg;
  assign stat.used   = used;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (sel_install) begin
      used <= 1'b1;
    end else if (cmd.do_replace && hit_np && (cmd.np != cmd.pg)) begin
      used <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel_install) begin
      page  <= cmd.pg;
      count <= COUNT_BITS'(1);
    end else if (cmd.do_replace && hit_pg) begin
      page  <= cmd.np;
      count <= COUNT_BITS'(1);
    end else if (cmd.do_access && hit_pg && (count != COUNT_MAX)) begin
      count <= count + COUNT_BITS'(1);
    end else if (cmd.do_clear && used && (PAGES_CFG_W'(page) < cmd.pages_lim)) begin
      count <= '0;
    end
  end

  // scan stage: strict less keeps the lower frame on ties
  assign take = used && in_range && (!cin.found || (count < cin.best));

  always_comb begin
    cout_next = cin;
    if (take) begin
      cout_next.found = 1'b1;
      cout_next.best  = count;
      cout_next.page  = page;
    end
  end

  always_ff @(posedge clk) begin
    cout <= cout_next;
  end

endmodule

`default_nettype wire

// ----- hdl/lfu_page_replacement.sv -----
// top level of the lfu page replacement block: command decode, scan control, results
// depends on lfu_pkg, lfu_frame_cell and lfu_page_replacement_macros.svh
//
// channel   signals                                   handshake
// command   op, page, new_page, frame                 start & !busy
// result    victim_page, victim_found, ok             done, one cycle
// config    cfg_index, cfg_data                       cfg_valid & cfg_ready
//
// access, replace, clear, install and unknown ops: result in the cycle after accept,
// and a new command may be accepted in that same cycle
// select: the candidate walks the frame chain one cell per cycle; busy while in ST_SCAN,
// until scan_cnt reaches NUM_FRAMES, then the result is registered from the chain end
// synchronous reset clears all frames; the result side cannot stall
`default_nettype none

`include "lfu_page_replacement_macros.svh"

module lfu_page_replacement (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  output logic                            busy,
  input  wire  [2:0]                      op,
  input  wire  [lfu_pkg::PAGE_W-1:0]      page,
  input  wire  [lfu_pkg::PAGE_W-1:0]      new_page,
  input  wire  [lfu_pkg::FRAME_W-1:0]     frame,
  output logic                            done,
  output logic [lfu_pkg::PAGE_W-1:0]      victim_page,
  output logic                            victim_found,
  output logic                            ok,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire                             cfg_index,
  input  wire  [lfu_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lfu_pkg::*;

  state_t                  state;
  state_t                  state_next;
  logic [SCAN_W-1:0]       scan_cnt;
  logic [PAGES_CFG_W-1:0]  pages_in_use;
  logic [FRAMES_CFG_W-1:0] frames_in_use;
  logic                    accept;
  logic                    scan_last;
  op_t                     op_code;
  cell_cmd_t               cmd;
  cell_stat_t              stat [NUM_FRAMES];
  cand_t                   chain [NUM_FRAMES+1];
  logic [NUM_FRAMES-1:0]   hit_pg_vec;
  logic [NUM_FRAMES-1:0]   used_vec;
  logic                    present_pg;
  logic                    pg_ok;
  logic                    np_ok;
  logic                    fr_ok;
  logic                    ok_now;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use  <= PAGES_CFG_W'(NUM_PAGES);
      frames_in_use <= FRAMES_CFG_W'(NUM_FRAMES);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PAGES:  pages_in_use  <= cfg_data[PAGES_CFG_W-1:0];
        CFG_FRAMES: frames_in_use <= cfg_data[FRAMES_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept  = start && !busy;
  assign op_code = op_t'(op);

  always_comb begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      hit_pg_vec[i] = stat[i].hit_pg;
      used_vec[i]   = stat[i].used;
    end
  end

  assign present_pg = |hit_pg_vec;
  assign pg_ok      = (PAGES_CFG_W'(page) < pages_in_use);
  assign np_ok      = (PAGES_CFG_W'(new_page) < pages_in_use);
  assign fr_ok      = (FRAMES_CFG_W'(frame) < frames_in_use);

  always_comb begin
    cmd            = '0;
    cmd.pg         = page;
    cmd.np         = new_page;
    cmd.fr         = frame;
    cmd.pages_lim  = pages_in_use;
    cmd.frames_lim = frames_in_use;
    ok_now         = 1'b0;
    case (op_code)
      OP_ACCESS: begin
        ok_now        = pg_ok;
        cmd.do_access = accept && pg_ok;
      end
      OP_SELECT: begin
        ok_now = 1'b1;
      end
      OP_REPLACE: begin
        ok_now         = pg_ok && np_ok && present_pg;
        cmd.do_replace = accept && ok_now;
      end
      OP_CLEAR: begin
        ok_now       = 1'b1;
        cmd.do_clear = accept;
      end
      OP_INSTALL: begin
        ok_now         = pg_ok && fr_ok && !used_vec[frame] && !present_pg;
        cmd.do_install = accept && ok_now;
      end
      default: begin
        ok_now = 1'b0;
      end
    endcase
  end

  // frame chain, empty candidate enters at the head
  assign chain[0] = '0;

  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    lfu_frame_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .idx  (FRAME_W'(i)),
      .cmd  (cmd),
      .cin  (chain[i]),
      .cout (chain[i+1]),
      .stat (stat[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
    end else if (accept) begin
      scan_cnt <= '0;
    end else if (state == ST_SCAN) begin
      scan_cnt <= scan_cnt + SCAN_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (op_code == OP_SELECT)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    scan_last = 1'b0;
    unique case (state)
      ST_IDLE: ;
      ST_SCAN: begin
        busy      = 1'b1;
        scan_last = (scan_cnt == SCAN_W'(NUM_FRAMES));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && (op_code != OP_SELECT)) || scan_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (op_code != OP_SELECT)) begin
      victim_page  <= '0;
      victim_found <= 1'b0;
      ok           <= ok_now;
    end else if (scan_last) begin
      victim_page  <= chain[NUM_FRAMES].found ? chain[NUM_FRAMES].page : '0;
      victim_found <= chain[NUM_FRAMES].found;
      ok           <= 1'b1;
    end
  end

  `LFU_ASSERT_NEXT(a_select_busy, accept && (op_code == OP_SELECT), busy && !done)
  `LFU_ASSERT_NEXT(a_scan_result, scan_last, done && !busy && ok)
  `LFU_ASSERT_NOW(a_page_unique, 1'b1, $countones(hit_pg_vec) <= 1)
  `LFU_ASSERT_NOW(a_no_victim_zero, done && !victim_found, victim_page == '0)

endmodule

`default_nettype wire
